>>> sv/bbs_pkg.sv
package bbs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 8;
  localparam int FRAC_BITS  = 8;

  // Fixed field widths of the ports
  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W = 1;

  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIM_W   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH + 1 : MAX_HEIGHT + 1);
  localparam int INT_W   = COORD_W - FRAC_BITS;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [INT_W-1:0]      coord_int_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TL,
    ST_RD_TR,
    ST_RD_BL,
    ST_RD_BR,
    ST_WAIT,
    ST_HBLEND,
    ST_VBLEND
  } st_t;

  // Truncated linear blend: ((ONE-f)*a + f*b) >> F, written as a + floor(f*(b-a) / ONE)
  function automatic pix_t blend(pix_t a, pix_t b, frac_t f);
    logic signed [PIXEL_BITS:0]             diff;
    logic signed [PIXEL_BITS+FRAC_BITS+1:0] prod;
    logic signed [PIXEL_BITS+FRAC_BITS+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = (PIXEL_BITS+FRAC_BITS+2)'(diff) * $signed({1'b0, f});
    sum  = $signed({{(FRAC_BITS+2){1'b0}}, a}) + (prod >>> FRAC_BITS);
    return sum[PIXEL_BITS-1:0];
  endfunction

endpackage

>>> sv/bbs_pixel_ram.sv
module bbs_pixel_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    q <= mem[addr];
  end

endmodule

>>> sv/bounded_bilinear_sampler_unit.sv
// Write beat: stored at the accepting edge; busy stays low, no result.
// Sample beat: n = 1..4 pixel reads (one per cycle on the single-port pixel RAM), then a
//   data wait, a horizontal and a vertical blend; the strobe is registered from the
//   vertical-blend state, and the next beat may start in that strobe cycle.
// Out-of-range sample: no pixel reads; straight to the vertical blend, then the strobe.
// Reset (rst_n low, synchronous) returns to idle, sizes to 256; pixel RAM is not cleared.
module bounded_bilinear_sampler_unit import bbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [INDEX_W-1:0]    in_write_row,
  input  logic [INDEX_W-1:0]    in_write_col,
  input  logic [INDEX_W-1:0]    in_write_value,
  input  logic [COORD_W-1:0]    in_sample_row,
  input  logic [COORD_W-1:0]    in_sample_col,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [PIXEL_BITS-1:0] out_sample_value,
  output logic                  out_out_of_range
);

  st_t state_r, state_nxt, prev_state_r;

  logic [CFG_DATA_W-1:0] width_r, height_r;

  // Per-sample working registers
  addr_t base_addr_r;
  frac_t fr_r, fc_r;
  logic  oor_r;
  pix_t  pix_tl_r, pix_tr_r, pix_bl_r, pix_br_r;
  pix_t  top_r, bot_r;

  logic  out_valid_r, out_oor_r;
  pix_t  out_value_r;

  // RAM port
  logic  ram_we;
  addr_t ram_addr;
  pix_t  ram_q;

  // Accept-cycle decode
  logic       accept;
  logic       wr_in_store;
  dim_t       w_eff, h_eff;
  coord_int_t ir, ic;
  frac_t      fr_raw, fc_raw;
  logic       oor_in;
  addr_t      wr_addr;

  assign accept = start && !busy;

  // Size registers above the store maximum clamp to it
  assign w_eff = (32'(width_r) > 32'(MAX_WIDTH))   ? DIM_W'(MAX_WIDTH)  : DIM_W'(width_r);
  assign h_eff = (32'(height_r) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(height_r);

  assign ir     = in_sample_row[COORD_W-1:FRAC_BITS];
  assign ic     = in_sample_col[COORD_W-1:FRAC_BITS];
  assign fr_raw = in_sample_row[FRAC_BITS-1:0];
  assign fc_raw = in_sample_col[FRAC_BITS-1:0];
  assign oor_in = (32'(ir) >= 32'(h_eff)) || (32'(ic) >= 32'(w_eff));

  assign wr_in_store = (32'(in_write_row) < 32'(MAX_HEIGHT)) &&
                       (32'(in_write_col) < 32'(MAX_WIDTH));
  assign wr_addr = ADDR_W'(ADDR_W'(in_write_row) * ADDR_W'(MAX_WIDTH)) +
                   ADDR_W'(in_write_col);

  bbs_pixel_ram #(
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (PIXEL_BITS'(in_write_value)),
    .q     (ram_q)
  );

  // Next state: skip the right-hand column when fc is zero and the lower row when fr is zero
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && opcode_t'(in_opcode) == OP_SAMPLE) begin
          state_nxt = oor_in ? ST_VBLEND : ST_RD_TL;
        end
      end
      ST_RD_TL: begin
        if (fc_r != '0) begin
          state_nxt = ST_RD_TR;
        end else if (fr_r != '0) begin
          state_nxt = ST_RD_BL;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_RD_TR: state_nxt = (fr_r != '0) ? ST_RD_BL : ST_WAIT;
      ST_RD_BL: state_nxt = (fc_r != '0) ? ST_RD_BR : ST_WAIT;
      ST_RD_BR: state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_HBLEND;
      ST_HBLEND: state_nxt = ST_VBLEND;
      ST_VBLEND: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM address and write enable, busy
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = base_addr_r;
    busy     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ram_addr = wr_addr;
        ram_we   = accept && opcode_t'(in_opcode) == OP_WRITE && wr_in_store;
      end
      ST_RD_TL: ram_addr = base_addr_r;
      ST_RD_TR: ram_addr = base_addr_r + ADDR_W'(1);
      ST_RD_BL: ram_addr = base_addr_r + ADDR_W'(MAX_WIDTH);
      ST_RD_BR: ram_addr = base_addr_r + ADDR_W'(MAX_WIDTH) + ADDR_W'(1);
      default:  ram_addr = base_addr_r;
    endcase
  end

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_state_r <= ST_IDLE;
      out_valid_r  <= 1'b0;
      width_r      <= CFG_DATA_W'(MAX_WIDTH);
      height_r     <= CFG_DATA_W'(MAX_HEIGHT);
    end else begin
      state_r      <= state_nxt;
      prev_state_r <= state_r;
      out_valid_r  <= (state_r == ST_VBLEND);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath: latch the sample, capture each registered read word in the cycle after its address, then blend
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      base_addr_r <= ADDR_W'(ADDR_W'(ir) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(ic);
      oor_r       <= oor_in;
      // Clamp at the last row or column: drop the fraction so no neighbour past the edge
      fr_r <= (32'(ir) + 1 == 32'(h_eff)) ? '0 : fr_raw;
      fc_r <= (32'(ic) + 1 == 32'(w_eff)) ? '0 : fc_raw;
    end
    case (prev_state_r)
      ST_RD_TL: pix_tl_r <= ram_q;
      ST_RD_TR: pix_tr_r <= ram_q;
      ST_RD_BL: pix_bl_r <= ram_q;
      ST_RD_BR: pix_br_r <= ram_q;
      default: ;
    endcase
    if (state_r == ST_HBLEND) begin
      top_r <= (fc_r != '0) ? blend(pix_tl_r, pix_tr_r, fc_r) : pix_tl_r;
      bot_r <= (fc_r != '0) ? blend(pix_bl_r, pix_br_r, fc_r) : pix_bl_r;
    end
    if (state_r == ST_VBLEND) begin
      out_oor_r <= oor_r;
      if (oor_r) begin
        out_value_r <= '0;
      end else begin
        out_value_r <= (fr_r != '0) ? blend(top_r, bot_r, fr_r) : top_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_out_of_range = out_oor_r;

endmodule

>>> sv/bbs_checker.sv
module bbs_checker import bbs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_opcode,
  input logic                  out_valid,
  input logic [PIXEL_BITS-1:0] out_sample_value,
  input logic                  out_out_of_range
);

  // A result is shown only while the block is idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // Out-of-range results carry zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_sample_value == '0)
    else $error("out-of-range result is not zero");

  // A write beat completes in its own cycle
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && opcode_t'(in_opcode) == OP_WRITE |=> !busy && !out_valid)
    else $error("write beat held the block or gave a result");

  // A sample beat occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && opcode_t'(in_opcode) == OP_SAMPLE |=> busy)
    else $error("sample beat did not raise busy");

endmodule

bind bounded_bilinear_sampler_unit bbs_checker u_bbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_sample_value (out_sample_value),
  .out_out_of_range (out_out_of_range)
);
